// ----- rtl/core/vdi_pkg.sv -----
// ----------------------------------------------------------------------------
// vdi_pkg
// Shared types and constants of the vertex dedup indexer.
// ----------------------------------------------------------------------------
package vdi_pkg;

  localparam int WORD_W             = 64;
  localparam int INDEX_W            = 10;
  localparam int DEF_TABLE_CAPACITY = 1024;

  // One vertex beat: start flag plus six packed 64-bit words
  typedef struct packed {
    logic              start_mesh;
    logic [WORD_W-1:0] pos_xy;
    logic [WORD_W-1:0] pos_z_norm_x;
    logic [WORD_W-1:0] norm_yz;
    logic [WORD_W-1:0] col_rg;
    logic [WORD_W-1:0] col_b_uv_x;
    logic [WORD_W-1:0] uv_yz;
  } vert_t;

  // Stored key of one unique vertex
  typedef struct packed {
    logic [WORD_W-1:0] pos_xy;
    logic [WORD_W-1:0] pos_z_norm_x;
    logic [WORD_W-1:0] norm_yz;
    logic [WORD_W-1:0] col_rg;
    logic [WORD_W-1:0] col_b_uv_x;
    logic [WORD_W-1:0] uv_yz;
  } key_t;

  // One result beat
  typedef struct packed {
    logic [INDEX_W-1:0] vertex_index;
    logic               is_new;
    logic               table_overflow;
  } res_t;

endpackage

// ----- rtl/core/vdi_table.sv -----
// ----------------------------------------------------------------------------
// vdi_table
// Unique vertex store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module vdi_table #(
  parameter int TABLE_CAPACITY = vdi_pkg::DEF_TABLE_CAPACITY,
  localparam int AW = (TABLE_CAPACITY > 1) ? $clog2(TABLE_CAPACITY) : 1
) (
  input  logic           clk,
  input  logic           wr_en,
  input  logic [AW-1:0]  wr_addr,
  input  vdi_pkg::key_t  wr_data,
  input  logic           rd_en,
  input  logic [AW-1:0]  rd_addr,
  output vdi_pkg::key_t  rd_data
);

  vdi_pkg::key_t mem [TABLE_CAPACITY];

  // Write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read one entry, data registered
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- rtl/core/vertex_dedup_indexer_top.sv -----
// ----------------------------------------------------------------------------
// vertex_dedup_indexer_top
// Index buffer builder: looks each vertex up in a table of unique vertices
// and appends it when no bitwise equal entry exists and the table has room.
// ----------------------------------------------------------------------------
//   channel | dir | handshake              | payload
//   vert    | in  | vert_valid / vert_stall | vdi_pkg::vert_t
//   res     | out | res_valid  / res_stall  | vdi_pkg::res_t
//
// A vertex with no match holds the input while it is accepted, while each
// stored entry is read through a single port into one shared 384-bit
// comparator, while the last entry is compared, while the scan is left and
// while the result is posted; an empty table skips the reads and compares.
// A hit ends the scan early. Reset is synchronous and clears only control
// state; the table needs no clearing pass. A stalled result is held in the
// output register while the next vertex is accepted and searched.
// ----------------------------------------------------------------------------
module vertex_dedup_indexer_top #(
  parameter int TABLE_CAPACITY = vdi_pkg::DEF_TABLE_CAPACITY
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           vert_valid,
  output logic           vert_stall,
  input  vdi_pkg::vert_t vert,
  output logic           res_valid,
  input  logic           res_stall,
  output vdi_pkg::res_t  res
);

  localparam int AW = (TABLE_CAPACITY > 1) ? $clog2(TABLE_CAPACITY) : 1;
  localparam int CW = $clog2(TABLE_CAPACITY + 1);
  localparam int IW = vdi_pkg::INDEX_W;
  localparam logic [CW-1:0] CAP = CW'(TABLE_CAPACITY);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t         state;
  vdi_pkg::key_t  key;
  logic [CW-1:0]  count;
  logic [CW-1:0]  ptr;
  logic [AW-1:0]  cmp_idx;
  logic           rd_vld;
  logic           found;
  logic [AW-1:0]  hit_idx;

  logic           accept;
  logic           hit;
  logic           out_free;
  logic           rd_en;
  logic           wr_en;
  vdi_pkg::key_t  rd_data;
  logic [CW+IW-1:0] count_ext;
  logic [AW+IW-1:0] hit_ext;

  assign accept   = vert_valid && !vert_stall;
  assign vert_stall = (state != S_IDLE);
  assign hit      = rd_vld && (rd_data == key);
  assign out_free = !res_valid || !res_stall;
  assign rd_en    = (state == S_SCAN) && (ptr < count) && !hit;
  assign wr_en    = (state == S_DONE) && out_free && !found && (count < CAP);
  assign count_ext = {{IW{1'b0}}, count};
  assign hit_ext   = {{IW{1'b0}}, hit_idx};

  vdi_table #(
    .TABLE_CAPACITY (TABLE_CAPACITY)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count[AW-1:0]),
    .wr_data (key),
    .rd_en   (rd_en),
    .rd_addr (ptr[AW-1:0]),
    .rd_data (rd_data)
  );

  // Sequence accept, scan and result post
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      ptr       <= '0;
      rd_vld    <= 1'b0;
      found     <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      // drop a result once taken, unless a new one is posted now
      if (res_valid && !res_stall && (state != S_DONE)) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            key <= '{pos_xy:       vert.pos_xy,
                     pos_z_norm_x: vert.pos_z_norm_x,
                     norm_yz:      vert.norm_yz,
                     col_rg:       vert.col_rg,
                     col_b_uv_x:   vert.col_b_uv_x,
                     uv_yz:        vert.uv_yz};
            if (vert.start_mesh) begin
              count <= '0;
            end
            ptr    <= '0;
            rd_vld <= 1'b0;
            found  <= 1'b0;
            state  <= S_SCAN;
          end
        end
        S_SCAN: begin
          priority if (hit) begin
            found   <= 1'b1;
            hit_idx <= cmp_idx;
            rd_vld  <= 1'b0;
            state   <= S_DONE;
          end else if (ptr < count) begin
            // advance to next entry
            rd_vld  <= 1'b1;
            cmp_idx <= ptr[AW-1:0];
            ptr     <= ptr + CW'(1);
          end else if (rd_vld) begin
            // wait for the last read to compare
            rd_vld <= 1'b0;
          end else begin
            found <= 1'b0;
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            res_valid <= 1'b1;
            priority if (found) begin
              res.vertex_index   <= hit_ext[IW-1:0];
              res.is_new         <= 1'b0;
              res.table_overflow <= 1'b0;
            end else if (count < CAP) begin
              res.vertex_index   <= count_ext[IW-1:0];
              res.is_new         <= 1'b1;
              res.table_overflow <= 1'b0;
              count              <= count + CW'(1);
            end else begin
              res.vertex_index   <= '0;
              res.is_new         <= 1'b0;
              res.table_overflow <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Fill count stays within capacity
  a_count_cap: assert property (@(posedge clk) disable iff (rst) count <= CAP)
    else $error("unique count above capacity");

  // Scan pointer never passes the fill count
  a_ptr_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (ptr <= count))
    else $error("scan pointer beyond fill count");

  // Start flag empties the table
  a_start_clear: assert property (@(posedge clk) disable iff (rst)
    (accept && vert.start_mesh) |=> (count == '0))
    else $error("start of mesh did not clear table");

  // A result is never both new and overflowed
  a_res_flags: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.is_new && res.table_overflow))
    else $error("result both new and overflowed");

endmodule
